// File: sv/fwt_pkg.sv
// Shared types and codes for the futex wait table.
package fwt_pkg;

	localparam logic CMD_WAIT = 1'b0;
	localparam logic CMD_WAKE = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OFF      = 3'd1;
	localparam logic [2:0] ST_NOTASK   = 3'd2;
	localparam logic [2:0] ST_UNMAPPED = 3'd3;
	localparam logic [2:0] ST_CHANGED  = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_BADLIMIT = 3'd6;

	localparam logic [4:0] COUNT_MAX = 5'd31;

	typedef struct packed {
		logic        command;
		logic [31:0] word_address;
		logic [31:0] expected_value;
		logic [31:0] current_value;
		logic        word_mapped;
		logic [31:0] space_id;
		logic        task_present;
		logic [7:0]  task_id;
		logic [7:0]  wake_limit;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic       is_wake_notice;
		logic [7:0] woken_task;
		logic [4:0] woken_count;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] space;
		logic [7:0]  task_id;
	} entry_t;

endpackage

// File: sv/futex_wait_table_core.sv
// Futex wait table: waiter slots keyed by word address and space id, scanned one slot at a time.
//
//  channel | dir | handshake          | beat
//  in      | in  | in_valid/in_stall  | fwt_pkg::in_t, one command
//  out     | out | out_valid/out_stall| fwt_pkg::out_t, notices then a final result
//  cfg     | in  | cfg_valid/cfg_ready| enable bit, always ready
//
// A command is accepted, checked, then visits slots in turn with a slot memory read and then a
// key compare; a wake ends with its final wake count beat, a wait at the first free slot.
// Errors found at the check end the command there; a full table is reported at the last slot.
// Reset clears the used bits and enable; slot contents need no clearing.
// A stalled output holds the scan in place where a new beat is due, until the pending beat is taken.
module futex_wait_table_core #(
	parameter int SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  fwt_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output fwt_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);
	import fwt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_READ  = 5'b00100,
		S_CMP   = 5'b01000,
		S_FINAL = 5'b10000
	} state_t;

	state_t          state_q;
	logic            enable_q;
	in_t             cmd_q;
	logic [31:0]     key_space_q;
	logic [CW-1:0]   limit_q;
	logic [CW-1:0]   woken_q;
	logic [IW-1:0]   idx_q;
	logic [SLOTS-1:0] used_q;
	entry_t          mem [SLOTS];
	entry_t          rd_q;
	logic            out_valid_q;
	out_t            out_q;

	logic            out_free;
	logic            in_acc;
	logic            match;
	logic [CW-1:0]   woken_nxt;
	logic [7:0]      woken_ext;
	logic [8:0]      limit_ext;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// one shared key compare: address and space id of the slot just read
	assign match     = used_q[idx_q] && (rd_q.addr == cmd_q.word_address)
	                   && (rd_q.space == key_space_q);
	assign woken_nxt = woken_q + CW'(1);
	assign woken_ext = 8'(woken_q);
	assign limit_ext = {1'b0, in_data.wake_limit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	// slot memory: one write port at claim, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == S_CMP && cmd_q.command == CMD_WAIT && !used_q[idx_q] && out_free) begin
			mem[idx_q] <= '{addr: cmd_q.word_address, space: cmd_q.space_id,
			                task_id: cmd_q.task_id};
		end
		if (state_q == S_READ) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q       <= in_data;
			key_space_q <= in_data.task_present ? in_data.space_id : 32'd0;
			limit_q     <= (limit_ext > 9'(SLOTS)) ? CW'(SLOTS) : CW'(in_data.wake_limit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			woken_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (out_free) begin
						idx_q   <= '0;
						woken_q <= '0;
						out_q   <= '{status: ST_OK, is_wake_notice: 1'b0, woken_task: 8'd0,
						            woken_count: 5'd0, last: 1'b1};
						state_q <= S_IDLE;
						if (cmd_q.command == CMD_WAKE) begin
							if (cmd_q.wake_limit == 8'd0) begin
								out_q.status <= ST_BADLIMIT;
								out_valid_q  <= 1'b1;
							end else if (!enable_q || cmd_q.word_address == 32'd0) begin
								out_valid_q <= 1'b1;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							out_valid_q <= 1'b1;
							if (!enable_q || cmd_q.word_address == 32'd0) begin
								out_q.status <= ST_OFF;
							end else if (!cmd_q.task_present) begin
								out_q.status <= ST_NOTASK;
							end else if (!cmd_q.word_mapped) begin
								out_q.status <= ST_UNMAPPED;
							end else if (cmd_q.current_value != cmd_q.expected_value) begin
								out_q.status <= ST_CHANGED;
							end else begin
								out_valid_q <= 1'b0;
								state_q     <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmd_q.command == CMD_WAIT) begin
						if (!used_q[idx_q]) begin
							if (out_free) begin
								used_q[idx_q] <= 1'b1;
								out_q       <= '{status: ST_OK, is_wake_notice: 1'b0,
								                woken_task: 8'd0, woken_count: 5'd0, last: 1'b1};
								out_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						end else if (idx_q == LAST_IDX) begin
							if (out_free) begin
								out_q       <= '{status: ST_FULL, is_wake_notice: 1'b0,
								                woken_task: 8'd0, woken_count: 5'd0, last: 1'b1};
								out_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_READ;
						end
					end else if (match) begin
						if (out_free) begin
							used_q[idx_q] <= 1'b0;
							woken_q     <= woken_nxt;
							out_q       <= '{status: ST_OK, is_wake_notice: 1'b1,
							                woken_task: rd_q.task_id, woken_count: 5'd0,
							                last: 1'b0};
							out_valid_q <= 1'b1;
							if (woken_nxt == limit_q || idx_q == LAST_IDX) begin
								state_q <= S_FINAL;
							end else begin
								idx_q   <= idx_q + IW'(1);
								state_q <= S_READ;
							end
						end
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_FINAL;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_READ;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_q       <= '{status: ST_OK, is_wake_notice: 1'b0, woken_task: 8'd0,
						                woken_count: (woken_ext > 8'(COUNT_MAX)) ? COUNT_MAX
						                             : woken_ext[4:0],
						                last: 1'b1};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/fwt_checker.sv
// Port-level checks on the futex wait table result channel, bound to the core module.
module fwt_port_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input fwt_pkg::out_t out_data
);
	import fwt_pkg::*;

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_notice_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_wake_notice |->
			!out_data.last && out_data.woken_count == 5'd0 && out_data.status == ST_OK)
		else $error("wake notice with bad fields");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.last && !out_data.is_wake_notice && out_data.woken_count == 5'd0)
		else $error("error result not a lone final beat");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 3'd7)
		else $error("status code out of range");

endmodule

bind futex_wait_table_core fwt_port_checker u_fwt_checker (.*);

// File: tb/sv/fwt_checker.sv
// Checker for the futex wait table: tracks the slot table, predicts each result beat and compares.
module fwt_checker #(
	parameter int SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  fwt_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_stall,
	input  fwt_pkg::out_t out_data,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic          cfg_data,
	output int            fails,
	output int            due,
	output int            beats,
	output int            notices,
	output logic [7:0]    status_seen
);
	import fwt_pkg::*;

	logic             table_on;
	logic [SLOTS-1:0] waiter_used;
	entry_t           waiter [SLOTS];
	out_t             due_results [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		fails++;
	endtask

	task automatic queue_result(input logic [2:0] st, input logic notice,
			input logic [7:0] tid, input logic [4:0] cnt, input logic fin);
		out_t r;
		r.status         = st;
		r.is_wake_notice = notice;
		r.woken_task     = tid;
		r.woken_count    = cnt;
		r.last           = fin;
		due_results.push_back(r);
	endtask

	// Applies one accepted command to the table copy and queues its result beats.
	task automatic table_step(input in_t c);
		logic [31:0] key_space;
		logic [2:0]  st;
		int          lim;
		int          woken;
		int          free_slot;
		if (c.command == CMD_WAKE) begin
			key_space = c.task_present ? c.space_id : 32'd0;
			lim = int'(c.wake_limit);
			woken = 0;
			if (lim == 0) begin
				queue_result(ST_BADLIMIT, 1'b0, 8'd0, 5'd0, 1'b1);
			end else if (!table_on || c.word_address == 32'd0) begin
				queue_result(ST_OK, 1'b0, 8'd0, 5'd0, 1'b1);
			end else begin
				if (lim > SLOTS) lim = SLOTS;
				for (int i = 0; i < SLOTS && woken < lim; i++) begin
					if (waiter_used[i] && waiter[i].addr == c.word_address &&
							waiter[i].space == key_space) begin
						waiter_used[i] = 1'b0;
						queue_result(ST_OK, 1'b1, waiter[i].task_id, 5'd0, 1'b0);
						woken++;
					end
				end
				queue_result(ST_OK, 1'b0, 8'd0, (woken > COUNT_MAX) ? COUNT_MAX : 5'(woken), 1'b1);
			end
		end else begin
			free_slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--) begin
				if (!waiter_used[i]) free_slot = i;
			end
			if (!table_on || c.word_address == 32'd0) st = ST_OFF;
			else if (!c.task_present) st = ST_NOTASK;
			else if (!c.word_mapped) st = ST_UNMAPPED;
			else if (c.current_value != c.expected_value) st = ST_CHANGED;
			else if (free_slot < 0) st = ST_FULL;
			else begin
				waiter_used[free_slot]     = 1'b1;
				waiter[free_slot].addr     = c.word_address;
				waiter[free_slot].space    = c.space_id;
				waiter[free_slot].task_id  = c.task_id;
				st = ST_OK;
			end
			queue_result(st, 1'b0, 8'd0, 5'd0, 1'b1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			table_on = 1'b0;
			waiter_used = '0;
			due_results.delete();
			status_seen = '0;
			due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) table_on = cfg_data;
			if (out_valid && !out_stall) begin
				beats++;
				if (due_results.size() == 0) begin
					report_mismatch("beat with nothing due", 32'(out_data), 32'd0);
				end else begin
					want = due_results.pop_front();
					status_seen[want.status] = 1'b1;
					if (want.is_wake_notice) notices++;
					if (out_data.status !== want.status)
						report_mismatch("status", out_data.status, want.status);
					if (out_data.is_wake_notice !== want.is_wake_notice)
						report_mismatch("is_wake_notice", out_data.is_wake_notice,
							want.is_wake_notice);
					if (out_data.woken_task !== want.woken_task)
						report_mismatch("woken_task", out_data.woken_task, want.woken_task);
					if (out_data.woken_count !== want.woken_count)
						report_mismatch("woken_count", out_data.woken_count, want.woken_count);
					if (out_data.last !== want.last)
						report_mismatch("last", out_data.last, want.last);
				end
			end
			if (in_valid && !in_stall) table_step(in_data);
			due <= due_results.size();
		end
	end

endmodule

// File: tb/sv/tb_futex_wait_table_core.sv
// Bench top for the futex wait table core: clock, reset, command stimulus and verdict.
module tb_futex_wait_table_core;
	import fwt_pkg::*;

	localparam int SLOTS        = 16;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 10;
	localparam int CYCLE_LIMIT  = 1000000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_stall;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data  = 1'b0;

	int         fails;
	int         due;
	int         beats;
	int         notices;
	logic [7:0] status_seen;
	int         cycles = 0;
	int         sent = 0;
	bit         steady = 1'b0;

	// small key pools so that wakes find their waiters
	logic [31:0] addr_pool [4] = '{32'h0000_1000, 32'h0000_1004, 32'h8000_0000, 32'hFFFF_FFFC};
	logic [31:0] space_pool [4] = '{32'h0, 32'h0000_0001, 32'h5A5A_A5A5, 32'hFFFF_FFFF};

	futex_wait_table_core #(.SLOTS(SLOTS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	fwt_checker #(.SLOTS(SLOTS)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fails       (fails),
		.due         (due),
		.beats       (beats),
		.notices     (notices),
		.status_seen (status_seen)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic in_t wait_cmd(input logic [31:0] a, input logic [31:0] sp,
			input logic [7:0] tid);
		in_t c;
		c.command        = CMD_WAIT;
		c.word_address   = a;
		c.expected_value = $urandom();
		c.current_value  = c.expected_value;
		c.word_mapped    = 1'b1;
		c.space_id       = sp;
		c.task_present   = 1'b1;
		c.task_id        = tid;
		c.wake_limit     = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// wait-only fields carry junk; the block must not look at them
	function automatic in_t wake_cmd(input logic [31:0] a, input logic [31:0] sp,
			input logic [7:0] lim);
		in_t c;
		c.command        = CMD_WAKE;
		c.word_address   = a;
		c.expected_value = $urandom();
		c.current_value  = $urandom();
		c.word_mapped    = 1'($urandom_range(0, 1));
		c.space_id       = sp;
		c.task_present   = 1'b1;
		c.task_id        = 8'($urandom_range(0, 255));
		c.wake_limit     = lim;
		return c;
	endfunction

	function automatic in_t random_cmd();
		in_t c;
		int  r;
		c.command = ($urandom_range(0, 99) < 55) ? CMD_WAIT : CMD_WAKE;
		r = $urandom_range(0, 99);
		c.word_address = (r < 5) ? 32'd0 : (r < 15) ? $urandom() : addr_pool[$urandom_range(0, 3)];
		c.expected_value = $urandom();
		c.current_value = ($urandom_range(0, 9) == 0) ?
			c.expected_value ^ ($urandom() | 32'd1) : c.expected_value;
		c.word_mapped = ($urandom_range(0, 12) != 0);
		c.space_id = ($urandom_range(0, 9) == 0) ? $urandom() : space_pool[$urandom_range(0, 3)];
		c.task_present = ($urandom_range(0, 12) != 0);
		c.task_id = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		c.wake_limit = (r < 5) ? 8'd0 : (r < 65) ? 8'($urandom_range(1, 4)) :
			(r < 90) ? 8'($urandom_range(5, 16)) : 8'($urandom_range(17, 255));
		return c;
	endfunction

	task automatic issue(input in_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	// hold off commands until every result is back and the scan has wound down
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// output side stalls in bursts
	initial begin
		int n;
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	initial begin
		in_t  c;
		logic en;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// still disabled out of reset
		issue(wait_cmd(addr_pool[0], space_pool[1], 8'd1));
		issue(wake_cmd(addr_pool[0], space_pool[1], 8'd0));
		issue(wake_cmd(addr_pool[0], space_pool[1], 8'd3));
		settle();
		write_enable(1'b1);

		// wait error ladder, then bad limit and null address on wake
		issue(wait_cmd(32'd0, space_pool[1], 8'd2));
		c = wait_cmd(addr_pool[0], space_pool[1], 8'd3);
		c.task_present = 1'b0;
		issue(c);
		c.task_present = 1'b1;
		c.word_mapped = 1'b0;
		issue(c);
		c.word_mapped = 1'b1;
		c.current_value = ~c.expected_value;
		issue(c);
		issue(wake_cmd(addr_pool[0], space_pool[1], 8'd0));
		issue(wake_cmd(32'd0, space_pool[1], 8'd1));

		// fill the table, first slot with all-ones keys, then one too many
		c = wait_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		c.expected_value = '1;
		c.current_value = '1;
		issue(c);
		for (int i = 1; i < SLOTS; i++) issue(wait_cmd(addr_pool[1], space_pool[2], 8'(i)));
		issue(wait_cmd(addr_pool[1], space_pool[2], 8'h00));

		// no task means space 0, which misses; then a limit clamped to the slot count
		c = wake_cmd(addr_pool[1], space_pool[2], 8'hFF);
		c.task_present = 1'b0;
		issue(c);
		c.task_present = 1'b1;
		issue(c);
		issue(wake_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1));

		// a waiter in space 0 is reached by a wake with no task
		issue(wait_cmd(addr_pool[2], 32'd0, 8'h5A));
		c = wake_cmd(addr_pool[2], 32'hDEAD_BEEF, 8'd2);
		c.task_present = 1'b0;
		issue(c);

		// random phases; enable off in two of them, one phase with no idling
		for (int p = 0; p < 6; p++) begin
			settle();
			en = (p != 1 && p != 4);
			write_enable(en);
			steady = (p == 3);
			for (int k = 0; k < (en ? 50 : 18); k++) issue(random_cmd());
		end
		steady = 1'b0;
		settle();

		$display("Ran %0d commands, %0d result beats checked, %0d of them wake notices.",
			sent, beats, notices);
		$display("Status codes seen, one bit per code: %b", status_seen);
		if (fails == 0 && due == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/fwt_pkg.sv
sv/futex_wait_table_core.sv
sv/fwt_checker.sv
tb/sv/fwt_checker.sv
tb/sv/tb_futex_wait_table_core.sv
